// ===== src/fsp_pkg.sv =====
// Shared constants and the sine duty ROM for the five-phase sine PWM block.
// No dependencies; imported by fsp_duty_cmp and five_phase_sine_pwm_top.
`default_nettype none

package fsp_pkg;

  localparam int TABLE_POINTS = 128;
  localparam int PHASE_COUNT  = 5;
  localparam int OUT_PHASES   = 5;
  localparam int IDX_W        = $clog2(TABLE_POINTS);
  localparam int PHASE_OFFSET = TABLE_POINTS / PHASE_COUNT;

  // floor((sin(j*6.28/128) + 1) * 63)
  localparam logic [IDX_W-1:0] SINE_ROM [TABLE_POINTS] = '{
     7'd63,  7'd66,  7'd69,  7'd72,  7'd75,  7'd78,  7'd81,  7'd84,
     7'd87,  7'd89,  7'd92,  7'd95,  7'd97, 7'd100, 7'd102, 7'd105,
    7'd107, 7'd109, 7'd111, 7'd113, 7'd115, 7'd117, 7'd118, 7'd119,
    7'd121, 7'd122, 7'd123, 7'd124, 7'd124, 7'd125, 7'd125, 7'd125,
    7'd125, 7'd125, 7'd125, 7'd125, 7'd124, 7'd124, 7'd123, 7'd122,
    7'd121, 7'd119, 7'd118, 7'd117, 7'd115, 7'd113, 7'd111, 7'd109,
    7'd107, 7'd105, 7'd103, 7'd100,  7'd98,  7'd95,  7'd92,  7'd90,
     7'd87,  7'd84,  7'd81,  7'd78,  7'd75,  7'd72,  7'd69,  7'd66,
     7'd63,  7'd60,  7'd56,  7'd53,  7'd50,  7'd47,  7'd44,  7'd41,
     7'd38,  7'd36,  7'd33,  7'd30,  7'd28,  7'd25,  7'd23,  7'd20,
     7'd18,  7'd16,  7'd14,  7'd12,  7'd10,   7'd9,   7'd7,   7'd6,
      7'd4,   7'd3,   7'd2,   7'd1,   7'd1,   7'd0,   7'd0,   7'd0,
      7'd0,   7'd0,   7'd0,   7'd0,   7'd1,   7'd1,   7'd2,   7'd3,
      7'd4,   7'd5,   7'd7,   7'd8,  7'd10,  7'd12,  7'd14,  7'd16,
     7'd18,  7'd20,  7'd22,  7'd25,  7'd27,  7'd30,  7'd33,  7'd35,
     7'd38,  7'd41,  7'd44,  7'd47,  7'd50,  7'd53,  7'd56,  7'd59
  };

endpackage

`default_nettype wire

// ===== src/fsp_duty_cmp.sv =====
// Per-phase ROM lookup and slot compare: one high-side bit for each phase.
// Depends on fsp_pkg.
`default_nettype none

module fsp_duty_cmp
  import fsp_pkg::*;
(
  input  wire logic [IDX_W-1:0]      sample_index,
  input  wire logic [IDX_W-1:0]      slot_counter,
  output      logic [OUT_PHASES-1:0] phase_high
);

  for (genvar k = 1; k <= OUT_PHASES; k++) begin : g_phase
    if (k <= PHASE_COUNT) begin : g_on
      localparam logic [IDX_W-1:0] SHIFT = IDX_W'((k * PHASE_OFFSET) % TABLE_POINTS);
      logic [IDX_W-1:0] rom_idx;
      logic [IDX_W-1:0] duty;

      // wrap modulo the table size for free in IDX_W bits
      assign rom_idx = sample_index - SHIFT;
      assign duty    = SINE_ROM[rom_idx];
      assign phase_high[k-1] = (slot_counter < duty);
    end else begin : g_off
      assign phase_high[k-1] = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== src/five_phase_sine_pwm_top.sv =====
// Top level of the five-phase sine PWM: stream ports, step register, slot and
// sample counters, result register. Depends on fsp_pkg and fsp_duty_cmp.
//
//   channel   direction  handshake                    payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  tdata[0] = tick
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata[4:0] = phase a..e, tlast = period_end
//   cfg       in         cfg_valid/cfg_ready          cfg_data = step_size
//
// One tick is taken per cycle while s_axis_tready is high; its result
// appears in the result register in the cycle after the transfer. The only logic between
// the counters and that register is five ROM lookups with compares plus one 8-bit add.
// rst clears the counters and the result register's valid flag and sets step_size to 1.
// A stalled output holds the result and pulls s_axis_tready low only while
// the result register is full and not being drained.
`default_nettype none

module five_phase_sine_pwm_top
  import fsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,

  input  wire logic       s_axis_tvalid,
  output      logic       s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [0] tick, [7:1] zero fill

  output      logic       m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output      logic [7:0] m_axis_tdata,   // [0] phase_a_high .. [4] phase_e_high, [7:5] zero
  output      logic       m_axis_tlast,   // period_end

  input  wire logic       cfg_valid,
  output      logic       cfg_ready,
  input  wire logic [6:0] cfg_data        // step_size
);

  logic [IDX_W-1:0]      step_size;
  logic [IDX_W-1:0]      slot_counter;
  logic [IDX_W-1:0]      slot_counter_next;
  logic [IDX_W-1:0]      sample_index;
  logic [IDX_W-1:0]      sample_index_next;
  logic [IDX_W-1:0]      eff_step;
  logic [IDX_W:0]        slot_sum;
  logic [IDX_W:0]        sample_sum;
  logic                  last_slot;
  logic                  tick;
  logic                  in_xfer;
  logic [OUT_PHASES-1:0] phase_high;
  logic                  out_valid;
  logic [OUT_PHASES-1:0] out_phase;
  logic                  out_last;

  // config writes are always accepted and land in the next cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= IDX_W'(1);
    end else if (cfg_valid) begin
      step_size <= cfg_data;
    end
  end

  // a zero step behaves as one
  assign eff_step = (step_size == '0) ? IDX_W'(1) : step_size;

  assign tick    = s_axis_tdata[0];
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // advance the slot; on wrap, advance the sample index the same way
  always_comb begin
    slot_sum          = {1'b0, slot_counter} + {1'b0, eff_step};
    sample_sum        = {1'b0, sample_index} + {1'b0, eff_step};
    last_slot         = slot_sum[IDX_W];
    slot_counter_next = last_slot ? '0 : slot_sum[IDX_W-1:0];
    sample_index_next = sample_index;
    if (last_slot) begin
      sample_index_next = sample_sum[IDX_W] ? '0 : sample_sum[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_counter <= '0;
      sample_index <= '0;
    end else if (in_xfer && tick) begin
      slot_counter <= slot_counter_next;
      sample_index <= sample_index_next;
    end
  end

  fsp_duty_cmp u_duty_cmp (
    .sample_index (sample_index),
    .slot_counter (slot_counter),
    .phase_high   (phase_high)
  );

  // result register: take a new item whenever it is empty or being drained
  assign s_axis_tready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_phase <= phase_high;
      out_last  <= tick && last_slot;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(8 - OUT_PHASES)'(0), out_phase};
  assign m_axis_tlast  = out_last;

endmodule

`default_nettype wire

// ===== verif/tb_five_phase_sine_pwm_top.sv =====
// Self-checking testbench for five_phase_sine_pwm_top: drives tick transfers and
// step_size writes, predicts every phase bit and period_end, compares in order.
// Depends only on the RTL (five_phase_sine_pwm_top and, through it, fsp_pkg and fsp_duty_cmp).
`default_nettype none

module tb_five_phase_sine_pwm_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 5;
  localparam int SLOTS = 128;
  localparam bit [6:0] PHASE_SHIFT = 7'd25;  // 128 slots split over five phases
  localparam int RANDOM_ROUNDS = 8;
  localparam int ROUND_ITEMS = 50;
  localparam int IDLE_PERCENT = 36;

  // Duty per sample: floor((sin(j*6.28/128) + 1) * 63)
  localparam bit [6:0] DUTY_ROM [SLOTS] = '{
     63,  66,  69,  72,  75,  78,  81,  84,  87,  89,  92,  95,  97, 100, 102, 105,
    107, 109, 111, 113, 115, 117, 118, 119, 121, 122, 123, 124, 124, 125, 125, 125,
    125, 125, 125, 125, 124, 124, 123, 122, 121, 119, 118, 117, 115, 113, 111, 109,
    107, 105, 103, 100,  98,  95,  92,  90,  87,  84,  81,  78,  75,  72,  69,  66,
     63,  60,  56,  53,  50,  47,  44,  41,  38,  36,  33,  30,  28,  25,  23,  20,
     18,  16,  14,  12,  10,   9,   7,   6,   4,   3,   2,   1,   1,   0,   0,   0,
      0,   0,   0,   0,   1,   1,   2,   3,   4,   5,   7,   8,  10,  12,  14,  16,
     18,  20,  22,  25,  27,  30,  33,  35,  38,  41,  44,  47,  50,  53,  56,  59
  };

  typedef struct packed {
    bit [PHASES-1:0] high;  // [0] phase a .. [4] phase e
    bit              last;
  } pwm_slot_t;

  // Tracks step, slot and sample, holds the predicted slot outputs in order.
  class pwm_scoreboard;
    bit [6:0]    step_reg;
    bit [6:0]    slot;
    bit [6:0]    sample;
    pwm_slot_t   slot_q[$];
    int unsigned errors;

    function new();
      step_reg = 7'd1;
      slot     = '0;
      sample   = '0;
      errors   = 0;
    endfunction

    function void set_step(bit [6:0] value);
      step_reg = value;
    endfunction

    function int pending();
      return slot_q.size();
    endfunction

    // Predict the outputs of the current slot, then advance on a real tick.
    function void note_tick(bit tick);
      pwm_slot_t r;
      bit [6:0]  s;
      bit [6:0]  idx;
      bit [7:0]  sum;
      s = (step_reg == 7'd0) ? 7'd1 : step_reg;  // zero step behaves as one
      for (int k = 1; k <= PHASES; k++) begin
        idx = sample - 7'(k * PHASE_SHIFT);
        r.high[k-1] = slot < DUTY_ROM[idx];
      end
      r.last = 1'b0;
      if (tick) begin
        sum = {1'b0, slot} + {1'b0, s};
        r.last = sum > 8'd127;
        slot = r.last ? 7'd0 : sum[6:0];
        if (r.last) begin
          sum = {1'b0, sample} + {1'b0, s};
          sample = (sum > 8'd127) ? 7'd0 : sum[6:0];
        end
      end
      slot_q.push_back(r);
    endfunction

    function void check_result(bit [7:0] data, bit last);
      pwm_slot_t exp_slot;
      string     names [PHASES];
      names = '{"phase_a_high", "phase_b_high", "phase_c_high", "phase_d_high",
                "phase_e_high"};
      if (slot_q.size() == 0) begin
        $error("result transfer with nothing predicted: tdata=%h tlast=%b", data, last);
        errors++;
        return;
      end
      exp_slot = slot_q.pop_front();
      for (int k = 0; k < PHASES; k++) begin
        if (data[k] !== exp_slot.high[k]) begin
          $error("%s: expected %b, got %b", names[k], exp_slot.high[k], data[k]);
          errors++;
        end
      end
      if (data[7:5] !== 3'b000) begin
        $error("tdata zero fill: expected 000, got %b", data[7:5]);
        errors++;
      end
      if (last !== exp_slot.last) begin
        $error("period_end: expected %b, got %b", exp_slot.last, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [0] tick, [7:1] zero fill
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [0] phase_a_high .. [4] phase_e_high, [7:5] zero
  logic       m_axis_tlast;           // period_end
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data = 7'd1;        // step_size

  pwm_scoreboard sb = new();
  bit            calm = 1'b0;         // set while neither side may idle
  int unsigned   cycles = 0;

  five_phase_sine_pwm_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result sink: drop tready at random, except during the calm stretch.
  always @(posedge clk) begin
    m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Monitor: all values read here are the ones the block saw at this edge.
  // Check the outgoing transfer first; an incoming tick only yields next cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tlast);
      end
      if (cfg_valid && cfg_ready) begin
        sb.set_step(cfg_data);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_tick(s_axis_tdata[0]);
      end
    end
  end

  // Offer one tick, with random idle cycles ahead of it; return after the transfer.
  // Valid stays high on return so back-to-back ticks need no extra assignment.
  task automatic send_tick(input bit tick);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {7'd0, 1'($urandom_range(1))};
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, tick};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Hold off the source until every predicted slot has been delivered.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write step_size; only called with the block idle.
  task automatic write_step(input bit [6:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly real ticks, some idle slots; optionally pause halfway to drain.
  task automatic send_random_ticks(input int count, input bit pause_midway);
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) begin
        drain_results();
      end
      send_tick($urandom_range(99) < 85);
    end
  endtask

  initial begin
    bit [6:0] step_pick;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset step of one, idle slots mixed in.
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    drain_results();

    // Largest step: slot jumps straight to 127, then wraps and moves the sample.
    write_step(7'd127);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    drain_results();

    // Zero step advances as if it were one.
    write_step(7'd0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    drain_results();

    // Half-period step: two slots per period.
    write_step(7'd64);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    drain_results();

    // Random rounds, each with its own step; one round runs with no idling.
    for (int r = 0; r < RANDOM_ROUNDS; r++) begin
      case ($urandom_range(4))
        0:       step_pick = 7'd127;
        1:       step_pick = 7'd1;
        2:       step_pick = 7'd0;
        default: step_pick = 7'($urandom_range(126, 2));
      endcase
      write_step(step_pick);
      calm = (r == 4);
      send_random_ticks(ROUND_ITEMS, r == 2);
      drain_results();
      calm = 1'b0;
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      if (sb.pending() != 0) begin
        $error("%0d predicted slots never delivered", sb.pending());
      end
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== five_phase_sine_pwm_top.f =====
src/fsp_pkg.sv
src/fsp_duty_cmp.sv
src/five_phase_sine_pwm_top.sv
verif/tb_five_phase_sine_pwm_top.sv
